>>> src/tsog_pkg.sv
package tsog_pkg;

  localparam int INST_W      = 4;
  localparam int PRICE_W     = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_SIGMAS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_PERCENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRICE_OFFSET = 2'd2;

  localparam logic [3:0]  BAND_RST = 4'd2;
  localparam logic [6:0]  DEV_RST  = 7'd10;
  localparam logic [15:0] OFS_RST  = 16'd100;

  localparam int PCT_SCALE   = 100;
  localparam int DEV_MIN_CNT = 5;
  localparam int MOM_MIN_CNT = 3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_META, ST_SUM, ST_PREP1, ST_PREP2, ST_SQS_LO, ST_SQS_HI,
    ST_VAR, ST_SQD_LO, ST_SQD_HI, ST_KV, ST_DECIDE, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_COMMIT, OP_ISSUE, OP_PREP1, OP_PREP2, OP_SQS_LO,
    OP_SQS_HI, OP_VAR, OP_SQD_LO, OP_SQD_HI, OP_KV, OP_DECIDE, OP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic inst_ok;
    logic sum_done;
    logic has_result;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/tsog_ram.sv
module tsog_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/tsog_ctrl.sv
module tsog_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  tsog_pkg::dp_status_t st,
  output tsog_pkg::dp_cmd_t    cmd
);
  import tsog_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid && st.inst_ok) state_nxt = ST_META;
      ST_META:   state_nxt = ST_SUM;
      ST_SUM:    if (st.sum_done) state_nxt = ST_PREP1;
      ST_PREP1:  state_nxt = ST_PREP2;
      ST_PREP2:  state_nxt = ST_SQS_LO;
      ST_SQS_LO: state_nxt = ST_SQS_HI;
      ST_SQS_HI: state_nxt = ST_VAR;
      ST_VAR:    state_nxt = ST_SQD_LO;
      ST_SQD_LO: state_nxt = ST_SQD_HI;
      ST_SQD_HI: state_nxt = ST_KV;
      ST_KV:     state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_EMIT;
      ST_EMIT:   if (!st.has_result || st.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_CAPTURE;
      end
      ST_META:   cmd.op = OP_COMMIT;
      ST_SUM:    cmd.op = OP_ISSUE;
      ST_PREP1:  cmd.op = OP_PREP1;
      ST_PREP2:  cmd.op = OP_PREP2;
      ST_SQS_LO: cmd.op = OP_SQS_LO;
      ST_SQS_HI: cmd.op = OP_SQS_HI;
      ST_VAR:    cmd.op = OP_VAR;
      ST_SQD_LO: cmd.op = OP_SQD_LO;
      ST_SQD_HI: cmd.op = OP_SQD_HI;
      ST_KV:     cmd.op = OP_KV;
      ST_DECIDE: cmd.op = OP_DECIDE;
      ST_EMIT:   if (st.has_result && st.out_free) cmd.op = OP_LOAD;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> src/tsog_dp.sv
module tsog_dp #(
  parameter int WINDOW      = 10,
  parameter int INSTRUMENTS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [tsog_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  cfg_valid,
  input  logic [tsog_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsog_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  tsog_pkg::dp_cmd_t                     cmd,
  output tsog_pkg::dp_status_t                  st,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [tsog_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [tsog_pkg::OUT_TUSER_W-1:0]      out_tuser
);
  import tsog_pkg::*;

  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SLW = $clog2(WINDOW);
  localparam int MW  = CW + SLW;
  localparam int IW  = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
  localparam int AW  = (INSTRUMENTS * WINDOW > 1) ? $clog2(INSTRUMENTS * WINDOW) : 1;
  localparam int SW  = PRICE_W + CW;
  localparam int QW  = 2 * PRICE_W + CW;
  localparam int VW  = 2 * SW;
  localparam int KW  = VW + 8;
  localparam int HL  = (SW + 1) / 2;
  localparam int HH  = SW - HL;
  localparam int DLW = SW + 7;
  localparam int HMW = SW + 8;

  // configuration
  logic [3:0]  band_r;
  logic [6:0]  dev_pct_r;
  logic [15:0] ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r    <= BAND_RST;
      dev_pct_r <= DEV_RST;
      ofs_r     <= OFS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BAND_SIGMAS:  band_r    <= cfg_data[3:0];
        CFG_DEV_PERCENT:  dev_pct_r <= cfg_data[6:0];
        CFG_PRICE_OFFSET: ofs_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick capture
  logic [INST_W-1:0]  in_inst;
  logic [IW-1:0]      in_idx;
  logic [INST_W-1:0]  inst_r;
  logic [IW-1:0]      idx_r;
  logic [PRICE_W-1:0] price_r;
  logic [AW-1:0]      base_r;
  logic               vld_hit_r;
  logic [INSTRUMENTS-1:0] vld_r;

  assign in_inst    = in_tdata[INST_W-1:0];
  assign in_idx     = IW'(in_inst);
  assign st.inst_ok = 32'(in_inst) < 32'(INSTRUMENTS);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      inst_r    <= in_inst;
      idx_r     <= in_idx;
      price_r   <= in_tdata[INST_W +: PRICE_W];
      base_r    <= AW'(32'(in_idx) * 32'(WINDOW));
      vld_hit_r <= st.inst_ok && vld_r[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.op == OP_COMMIT) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // per-instrument fill count and write slot
  logic [MW-1:0]  meta_rd;
  logic [CW-1:0]  fill_old, fill_new;
  logic [SLW-1:0] slot_old, slot_new;
  logic [SLW:0]   back3, back2;

  tsog_ram #(.WIDTH(MW), .DEPTH(INSTRUMENTS)) u_meta_ram (
    .clk     (clk),
    .wr_en   (cmd.op == OP_COMMIT),
    .wr_addr (idx_r),
    .wr_data ({fill_new, slot_new}),
    .rd_en   (cmd.op == OP_CAPTURE),
    .rd_addr (in_idx),
    .rd_data (meta_rd)
  );

  always_comb begin
    fill_old = vld_hit_r ? meta_rd[MW-1:SLW] : '0;
    slot_old = vld_hit_r ? meta_rd[SLW-1:0] : '0;
    fill_new = (fill_old == CW'(WINDOW)) ? fill_old : fill_old + 1'b1;
    slot_new = (slot_old == SLW'(WINDOW - 1)) ? '0 : slot_old + 1'b1;
    back3    = {1'b0, slot_new} + (SLW + 1)'(WINDOW - 3);
    back2    = {1'b0, slot_new} + (SLW + 1)'(WINDOW - 2);
    if (back3 >= (SLW + 1)'(WINDOW)) back3 = back3 - (SLW + 1)'(WINDOW);
    if (back2 >= (SLW + 1)'(WINDOW)) back2 = back2 - (SLW + 1)'(WINDOW);
  end

  // window sweep: read, square, accumulate
  logic [CW-1:0]      cnt_r, rd_idx_r;
  logic [SLW-1:0]     idx_a_r, idx_b_r, idx1_r;
  logic               v1_r, v2_r, issue;
  logic [PRICE_W-1:0] win_rd, a_r, b_r;
  logic [2*PRICE_W-1:0] prod_r;
  logic [SW-1:0]      acc_s_r;
  logic [QW-1:0]      acc_q_r;
  logic [AW-1:0]      win_waddr, win_raddr;

  assign issue     = (cmd.op == OP_ISSUE) && (rd_idx_r < cnt_r);
  assign win_waddr = base_r + AW'(slot_old);
  assign win_raddr = base_r + AW'(rd_idx_r);
  assign st.sum_done = (rd_idx_r == cnt_r) && !v1_r && !v2_r;

  tsog_ram #(.WIDTH(PRICE_W), .DEPTH(INSTRUMENTS * WINDOW)) u_win_ram (
    .clk     (clk),
    .wr_en   (cmd.op == OP_COMMIT),
    .wr_addr (win_waddr),
    .wr_data (price_r),
    .rd_en   (issue),
    .rd_addr (win_raddr),
    .rd_data (win_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COMMIT) begin
      cnt_r    <= fill_new;
      idx_a_r  <= back3[SLW-1:0];
      idx_b_r  <= back2[SLW-1:0];
      rd_idx_r <= '0;
      acc_s_r  <= '0;
      acc_q_r  <= '0;
    end else begin
      if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        idx1_r   <= rd_idx_r[SLW-1:0];
      end
      if (v1_r) begin
        acc_s_r <= acc_s_r + SW'(win_rd);
        prod_r  <= win_rd * win_rd;
        if (idx1_r == idx_a_r) a_r <= win_rd;
        if (idx1_r == idx_b_r) b_r <= win_rd;
      end
      if (v2_r) begin
        acc_q_r <= acc_q_r + QW'(prod_r);
      end
    end
  end

  // signal arithmetic
  logic [SW-1:0]  np_r, d_r, sq_x;
  logic [VW-1:0]  wq_r, sq_acc_r, v_r;
  logic [KW-1:0]  kv_r;
  logic [7:0]     kk_r;
  logic [DLW-1:0] dev_lhs_r, lowm_r;
  logic [HMW-1:0] highm_r;
  logic [6:0]     lo_pct;
  logic [7:0]     hi_pct;
  logic           np_gt_r, np_lt_r, dev_r;
  logic [SW+HL-1:0] pl;
  logic [SW+HH-1:0] ph;

  assign lo_pct = 7'(PCT_SCALE) - dev_pct_r;
  assign hi_pct = 8'(PCT_SCALE) + 8'(dev_pct_r);
  assign sq_x   = (cmd.op == OP_SQS_LO || cmd.op == OP_SQS_HI) ? acc_s_r : d_r;
  assign pl     = sq_x * sq_x[HL-1:0];
  assign ph     = sq_x * sq_x[SW-1:HL];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PREP1: begin
        np_r    <= SW'(cnt_r) * SW'(price_r);
        wq_r    <= VW'(acc_q_r) * VW'(WINDOW);
        lowm_r  <= DLW'(acc_s_r) * DLW'(lo_pct);
        highm_r <= HMW'(acc_s_r) * HMW'(hi_pct);
        kk_r    <= 8'(band_r) * 8'(band_r);
      end
      OP_PREP2: begin
        dev_lhs_r <= DLW'(np_r) * DLW'(PCT_SCALE);
        d_r       <= (np_r >= acc_s_r) ? np_r - acc_s_r : acc_s_r - np_r;
        np_gt_r   <= np_r > acc_s_r;
        np_lt_r   <= np_r < acc_s_r;
      end
      OP_SQS_LO, OP_SQD_LO: sq_acc_r <= VW'(pl);
      OP_SQS_HI, OP_SQD_HI: sq_acc_r <= sq_acc_r + (VW'(ph) << HL);
      OP_VAR: begin
        v_r   <= wq_r - sq_acc_r;
        dev_r <= (32'(cnt_r) >= 32'(DEV_MIN_CNT)) &&
                 (((32'(dev_pct_r) < 32'(PCT_SCALE)) && (dev_lhs_r < lowm_r)) ||
                  (HMW'(dev_lhs_r) > highm_r));
      end
      OP_KV: kv_r <= KW'(v_r) * KW'(kk_r);
      default: ;
    endcase
  end

  // order decision
  logic               bo, mom, buy;
  logic [2:0]         mask;
  logic [PRICE_W:0]   p_plus;
  logic [PRICE_W-1:0] px;
  logic [INST_W-1:0]  res_inst_r;
  logic [PRICE_W-1:0] res_price_r;
  logic               res_buy_r, has_res_r;
  logic [2:0]         res_mask_r;

  always_comb begin
    bo     = (cnt_r == CW'(WINDOW)) && (KW'(sq_acc_r) > kv_r);
    mom    = (32'(cnt_r) >= 32'(MOM_MIN_CNT)) && (b_r > a_r) && (price_r > b_r);
    mask   = {mom, dev_r, bo};
    buy    = (bo && np_gt_r) || (dev_r && np_lt_r) || mom;
    p_plus = {1'b0, price_r} + (PRICE_W + 1)'(ofs_r);
    if (buy) begin
      px = p_plus[PRICE_W] ? '1 : p_plus[PRICE_W-1:0];
    end else begin
      px = (price_r >= PRICE_W'(ofs_r)) ? price_r - PRICE_W'(ofs_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DECIDE) begin
      res_inst_r  <= inst_r;
      res_price_r <= px;
      res_buy_r   <= buy;
      res_mask_r  <= mask;
      has_res_r   <= |mask;
    end
  end

  assign st.has_result = has_res_r;

  // output register
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  assign st.out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      out_data_r <= OUT_TDATA_W'({res_price_r, res_inst_r});
      out_user_r <= {res_mask_r, res_buy_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> src/tick_signal_order_generator_top.sv
// Tick signal order generator. Each tick (instrument, price) is appended to
// that instrument's window of the last WINDOW prices, then three signals are
// tested: band breakout on a full window (exact, on sums and squares), percent
// deviation from the window mean (five or more prices) and three strictly
// rising prices. Any hit yields one order beat; buy wins over sell and the
// price moves by price_offset, saturating. Ticks are handled one at a time: a
// tick for a known instrument is captured, the window RAM is read once per
// stored price, including the new one, then a fixed sequence of states runs
// around a shared two-pass squarer, and the order beat, if any, is loaded once
// the output register is free; only then can the next tick be taken. A tick
// for an instrument at or above INSTRUMENTS is taken and dropped without the
// controller leaving idle. The user must write configuration only while no
// tick is in flight; the block itself does not enforce this.
module tick_signal_order_generator_top #(
  parameter int WINDOW      = 10,
  parameter int INSTRUMENTS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tsog_pkg::IN_TDATA_W-1:0]     in_tdata,   // instrument[3:0], price[35:4]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tsog_pkg::OUT_TDATA_W-1:0]    out_tdata,  // order_instrument[3:0], order_price[35:4]
  output logic [tsog_pkg::OUT_TUSER_W-1:0]    out_tuser,  // is_buy[0], sig_flags[3:1]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsog_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsog_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tsog_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  tsog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tsog_dp #(.WINDOW(WINDOW), .INSTRUMENTS(INSTRUMENTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |-> st.out_free)
    else $error("order loaded over an untaken beat");

  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && st.inst_ok) |=> !in_tready)
    else $error("new tick taken while one is in flight");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.op == OP_LOAD))
    else $error("order beat without a load");

endmodule
